// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle forces a result in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/ccls_pkg.sv -----
package ccls_pkg;

    localparam int BYTE_W  = 8;
    localparam int CLASS_W = 3;
    localparam int COUNT_W = 2;

    localparam logic [CLASS_W-1:0] CLASS_GBK     = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_UTF8    = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_U16LE   = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_U16BE   = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 3'd4;

    localparam logic [BYTE_W-1:0] BYTE_EF    = 8'hEF;
    localparam logic [BYTE_W-1:0] BYTE_BB    = 8'hBB;
    localparam logic [BYTE_W-1:0] BYTE_BF    = 8'hBF;
    localparam logic [BYTE_W-1:0] BYTE_FF    = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_FE    = 8'hFE;
    localparam logic [BYTE_W-1:0] LEAD_MIN   = 8'h81;
    localparam logic [BYTE_W-1:0] TRAIL_MIN  = 8'h40;
    localparam logic [BYTE_W-1:0] ASCII_LIM  = 8'd128;

    localparam logic [COUNT_W-1:0] COUNT_ZERO = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_TWO  = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_FULL = 2'd3;

    // One byte held in the input register.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } byte_item_t;

endpackage

// ----- rtl/ccls_input_stage.sv -----
module ccls_input_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                data_valid,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic                advance,
    output logic                data_stall,
    output ccls_pkg::byte_item_t item
);
    import ccls_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;

    // Hold while the registered byte cannot move on.
    assign data_stall = valid_reg && !advance;
    assign valid_next = data_stall ? valid_reg : data_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && !data_stall)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign item = '{valid: valid_reg, data: data_reg, last: last_reg};

endmodule

// ----- rtl/ccls_scan.sv -----
module ccls_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccls_pkg::byte_item_t item,
    input  logic                 advance,
    output logic [2:0]           charset_class
);
    import ccls_pkg::*;

    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [BYTE_W-1:0]  first_reg,  first_next;
    logic [BYTE_W-1:0]  second_reg, second_next;
    logic               mark_reg,   mark_next;
    logic               await_reg,  await_next;
    logic               broken_reg, broken_next;
    logic [BYTE_W-1:0]  b;

    assign b = item.data;

    always_comb
    begin
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        mark_next   = mark_reg;
        await_next  = await_reg;
        broken_next = broken_reg;

        // file start capture and UTF-8 mark
        unique case (count_reg)
            COUNT_ZERO: first_next  = b;
            COUNT_ONE:  second_next = b;
            COUNT_TWO:  mark_next   = (first_reg == BYTE_EF) && (second_reg == BYTE_BB)
                                      && (b == BYTE_BF);
            default:    ;
        endcase
        if (count_reg != COUNT_FULL)
        begin
            count_next = count_reg + COUNT_ONE;
        end

        // GBK pairing rule; frozen once broken
        if (!broken_reg)
        begin
            if (await_reg)
            begin
                await_next = 1'b0;
                if (!(b >= TRAIL_MIN && b <= BYTE_FE))
                begin
                    broken_next = 1'b1;
                end
            end
            else if (b < ASCII_LIM)
            begin
                // single-byte char
            end
            else if (b >= LEAD_MIN && b <= BYTE_FE)
            begin
                await_next = 1'b1;
            end
            else
            begin
                broken_next = 1'b1;
            end
        end

        if (count_next != COUNT_FULL)
        begin
            charset_class = CLASS_UNKNOWN;
        end
        else if (mark_next)
        begin
            charset_class = CLASS_UTF8;
        end
        else if (first_next == BYTE_FF && second_next == BYTE_FE)
        begin
            charset_class = CLASS_U16LE;
        end
        else if (first_next == BYTE_FE && second_next == BYTE_FF)
        begin
            charset_class = CLASS_U16BE;
        end
        else if (!broken_next && !await_next)
        begin
            charset_class = CLASS_GBK;
        end
        else
        begin
            charset_class = CLASS_UNKNOWN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= COUNT_ZERO;
            first_reg  <= '0;
            second_reg <= '0;
            mark_reg   <= 1'b0;
            await_reg  <= 1'b0;
            broken_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (item.last)
            begin
                count_reg  <= COUNT_ZERO;
                first_reg  <= '0;
                second_reg <= '0;
                mark_reg   <= 1'b0;
                await_reg  <= 1'b0;
                broken_reg <= 1'b0;
            end
            else
            begin
                count_reg  <= count_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                mark_reg   <= mark_next;
                await_reg  <= await_next;
                broken_reg <= broken_next;
            end
        end
    end

endmodule

// ----- rtl/ccls_result_reg.sv -----
module ccls_result_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [2:0] class_in,
    input  logic       class_stall,
    output logic       class_valid,
    output logic [2:0] charset_class
);
    import ccls_pkg::*;

    logic               valid_reg, valid_next;
    logic [CLASS_W-1:0] class_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!class_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            class_reg <= class_in;
        end
    end

    assign class_valid   = valid_reg;
    assign charset_class = class_reg;

endmodule

// ----- rtl/text_charset_classifier.sv -----
// Result: a byte marked last shows its class on the output in the cycle after its transfer.
// Throughput: one byte per cycle; only a stalled result holding back a later last byte stops input.
// The per-byte state update (count, start bytes, GBK pairing) is combinational and sets that rate.
// Reset: rst_n is asynchronous, active low; it empties both registers and clears the scan state.
`include "assert_macros.svh"

module text_charset_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       class_valid,
    input  logic       class_stall,
    output logic [2:0] charset_class
);
    import ccls_pkg::*;

    byte_item_t         item;
    logic               advance;
    logic [CLASS_W-1:0] class_calc;

    // The registered byte moves on unless it is a last byte and the result register is still
    // occupied by a class that is not being taken this cycle. Bytes that give no result
    // always move on, so the output side can only stall input at file boundaries.
    assign advance = item.valid && (!item.last || !class_valid || !class_stall);

    // Input register: one byte of the file and its end flag.
    ccls_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .advance    (advance),
        .data_stall (data_stall),
        .item       (item)
    );

    // Per-file state update and class decision, all in one short combinational step.
    ccls_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .advance       (advance),
        .charset_class (class_calc)
    );

    // Result register: loaded only on the transfer of a last byte.
    ccls_result_reg u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && item.last),
        .class_in      (class_calc),
        .class_stall   (class_stall),
        .class_valid   (class_valid),
        .charset_class (charset_class)
    );

    // A last byte that moves on always produces a class in the next cycle.
    `ASSERT_NEXT(a_last_gives_class, clk, rst_n, advance && item.last, class_valid,
        "last byte produced no class")

    // Input is held back only for a last byte blocked by a stalled result.
    `ASSERT_ALWAYS(a_stall_cause, clk, rst_n,
        !data_stall || (item.valid && item.last && class_valid && class_stall),
        "input stalled without a blocked result")

    // Only defined class codes leave the block.
    `ASSERT_ALWAYS(a_class_code, clk, rst_n,
        !class_valid || charset_class == CLASS_GBK || charset_class == CLASS_UTF8
        || charset_class == CLASS_U16LE || charset_class == CLASS_U16BE
        || charset_class == CLASS_UNKNOWN,
        "undefined class code on output")

endmodule
